>>> rtl/mprg_pkg.sv
// package for the motor period ramp generator
// holds widths, register indexes, configuration and result types, band selection
// no dependencies
package mprg_pkg;

	localparam int PERIOD_BITS = 8;
	localparam int DWELL_BITS = 8;
	localparam int CFG_BITS = 8;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 5;
	localparam int REG_IDX_BITS = 3;

	localparam logic [CFG_BITS-1:0] START_PERIOD_RST = CFG_BITS'(245);
	localparam logic [CFG_BITS-1:0] HIGH_THRESH_RST = CFG_BITS'(150);
	localparam logic [CFG_BITS-1:0] LOW_THRESH_RST = CFG_BITS'(50);
	localparam logic [CFG_BITS-1:0] DWELL_SHORT_RST = CFG_BITS'(5);
	localparam logic [CFG_BITS-1:0] DWELL_MIDDLE_RST = CFG_BITS'(10);
	localparam logic [CFG_BITS-1:0] DWELL_LONG_RST = CFG_BITS'(20);

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_START_PERIOD = 3'd0,
		REG_HIGH_THRESH  = 3'd1,
		REG_LOW_THRESH   = 3'd2,
		REG_DWELL_SHORT  = 3'd3,
		REG_DWELL_MIDDLE = 3'd4,
		REG_DWELL_LONG   = 3'd5
	} reg_idx_t;

	typedef enum logic {
		OP_TICK   = 1'b0,
		OP_TARGET = 1'b1
	} op_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] start_period;
		logic [CFG_BITS-1:0] high_thresh;
		logic [CFG_BITS-1:0] low_thresh;
		logic [CFG_BITS-1:0] dwell_short;
		logic [CFG_BITS-1:0] dwell_middle;
		logic [CFG_BITS-1:0] dwell_long;
	} cfg_t;

	typedef struct packed {
		logic [PERIOD_BITS-1:0] period;
		logic                   driver_enable;
		logic                   ramping;
	} res_t;

	function automatic logic [DWELL_BITS-1:0] band_dwell(
		input logic [PERIOD_BITS-1:0] p,
		input cfg_t                   cfg
	);
		logic [DWELL_BITS-1:0] d;
		if (p > PERIOD_BITS'(cfg.high_thresh)) begin
			d = DWELL_BITS'(cfg.dwell_short);
		end else if (p > PERIOD_BITS'(cfg.low_thresh)) begin
			d = DWELL_BITS'(cfg.dwell_middle);
		end else begin
			d = DWELL_BITS'(cfg.dwell_long);
		end
		return d;
	endfunction

endpackage

>>> rtl/mprg_if.sv
// valid/ready channel interfaces for items and results
// depends on mprg_pkg
interface mprg_in_if;
	logic                            valid;
	logic                            ready;
	logic                            op;
	logic [mprg_pkg::PERIOD_BITS-1:0] target_period;

	modport source (output valid, output op, output target_period, input ready);
	modport sink (input valid, input op, input target_period, output ready);
endinterface

interface mprg_out_if;
	logic                            valid;
	logic                            ready;
	logic [mprg_pkg::PERIOD_BITS-1:0] period;
	logic                            driver_enable;
	logic                            ramping;

	modport source (output valid, output period, output driver_enable, output ramping,
		input ready);
	modport sink (input valid, input period, input driver_enable, input ramping,
		output ready);
endinterface

>>> rtl/mprg_apb.sv
// apb configuration register file for the ramp generator
// depends on mprg_pkg
module mprg_apb (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mprg_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [mprg_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [mprg_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                               pready,
	output mprg_pkg::cfg_t                     cfg
);
	mprg_pkg::cfg_t                  cfg_q;
	logic [mprg_pkg::CFG_BITS-1:0]   wdata;
	logic [mprg_pkg::CFG_BITS-1:0]   rdata;
	logic [mprg_pkg::REG_IDX_BITS-1:0] idx;
	logic                            wr_en;

	assign pready = 1'b1;
	assign idx = paddr[mprg_pkg::REG_IDX_BITS+1:2];
	assign wdata = pwdata[mprg_pkg::CFG_BITS-1:0];
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_period <= mprg_pkg::START_PERIOD_RST;
			cfg_q.high_thresh <= mprg_pkg::HIGH_THRESH_RST;
			cfg_q.low_thresh <= mprg_pkg::LOW_THRESH_RST;
			cfg_q.dwell_short <= mprg_pkg::DWELL_SHORT_RST;
			cfg_q.dwell_middle <= mprg_pkg::DWELL_MIDDLE_RST;
			cfg_q.dwell_long <= mprg_pkg::DWELL_LONG_RST;
		end else if (wr_en) begin
			case (idx)
				mprg_pkg::REG_START_PERIOD: cfg_q.start_period <= wdata;
				mprg_pkg::REG_HIGH_THRESH: cfg_q.high_thresh <= wdata;
				mprg_pkg::REG_LOW_THRESH: cfg_q.low_thresh <= wdata;
				mprg_pkg::REG_DWELL_SHORT: cfg_q.dwell_short <= wdata;
				mprg_pkg::REG_DWELL_MIDDLE: cfg_q.dwell_middle <= wdata;
				mprg_pkg::REG_DWELL_LONG: cfg_q.dwell_long <= wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mprg_pkg::REG_START_PERIOD: rdata = cfg_q.start_period;
			mprg_pkg::REG_HIGH_THRESH: rdata = cfg_q.high_thresh;
			mprg_pkg::REG_LOW_THRESH: rdata = cfg_q.low_thresh;
			mprg_pkg::REG_DWELL_SHORT: rdata = cfg_q.dwell_short;
			mprg_pkg::REG_DWELL_MIDDLE: rdata = cfg_q.dwell_middle;
			mprg_pkg::REG_DWELL_LONG: rdata = cfg_q.dwell_long;
			default: rdata = '0;
		endcase
	end

	assign prdata = mprg_pkg::APB_DATA_BITS'(rdata);

endmodule

>>> rtl/mprg_core.sv
// ramp state: current period, goal, dwell counter, enable and moving flags
// one item per cycle while accept is high, result computed from next state; depends on mprg_pkg
module mprg_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic                             op,
	input  logic [mprg_pkg::PERIOD_BITS-1:0] target_period,
	input  mprg_pkg::cfg_t                   cfg,
	output mprg_pkg::res_t                   res
);
	logic [mprg_pkg::PERIOD_BITS-1:0] cur_q, cur_d, goal_q, goal_d, stepped;
	logic [mprg_pkg::DWELL_BITS-1:0]  dwell_q, dwell_d;
	logic                             enabled_q, enabled_d, moving_q, moving_d;

	always_comb begin
		if (cur_q < goal_q) begin
			stepped = cur_q + mprg_pkg::PERIOD_BITS'(1);
		end else if (cur_q > goal_q) begin
			stepped = cur_q - mprg_pkg::PERIOD_BITS'(1);
		end else begin
			stepped = cur_q;
		end
	end

	always_comb begin
		cur_d = cur_q;
		goal_d = goal_q;
		dwell_d = dwell_q;
		enabled_d = enabled_q;
		moving_d = moving_q;
		if (op == mprg_pkg::OP_TARGET) begin
			goal_d = target_period;
			if (!enabled_q) begin
				cur_d = mprg_pkg::PERIOD_BITS'(cfg.start_period);
				enabled_d = 1'b1;
			end
			moving_d = (cur_d != target_period);
			dwell_d = mprg_pkg::band_dwell(cur_d, cfg);
		end else if (moving_q) begin
			if (dwell_q > mprg_pkg::DWELL_BITS'(1)) begin
				dwell_d = dwell_q - mprg_pkg::DWELL_BITS'(1);
			end else begin
				cur_d = stepped;
				moving_d = (stepped != goal_q);
				dwell_d = mprg_pkg::band_dwell(stepped, cfg);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			goal_q <= '0;
			dwell_q <= '0;
			enabled_q <= 1'b0;
			moving_q <= 1'b0;
		end else if (accept) begin
			cur_q <= cur_d;
			goal_q <= goal_d;
			dwell_q <= dwell_d;
			enabled_q <= enabled_d;
			moving_q <= moving_d;
		end
	end

	assign res.period = cur_d;
	assign res.driver_enable = enabled_d;
	assign res.ramping = moving_d;

	a_move_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> enabled_q)
		else $error("ramp running with driver disabled");

	a_idle_at_goal: assert property (@(posedge clk) disable iff (!arst_n)
		!moving_q |-> cur_q == goal_q)
		else $error("ramp stopped away from goal");

	a_idle_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == mprg_pkg::OP_TICK && !moving_q) |=>
		($stable(cur_q) && $stable(dwell_q)))
		else $error("tick changed state while not ramping");

	a_enable_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		enabled_q |=> enabled_q)
		else $error("driver enable dropped without reset");

endmodule

>>> rtl/mprg_obuf.sv
// two-entry result buffer: output register plus skid register
// depends on mprg_pkg
module mprg_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mprg_pkg::res_t push_data,
	output logic           can_push,
	output logic           out_valid,
	input  logic           out_ready,
	output mprg_pkg::res_t out_data
);
	mprg_pkg::res_t main_q, skid_q;
	logic           main_valid_q, skid_valid_q, pop;

	assign can_push = !skid_valid_q;
	assign pop = main_valid_q && out_ready;
	assign out_valid = main_valid_q;
	assign out_data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!main_valid_q || pop) begin
					main_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!main_valid_q || pop) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end else if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held without output entry");

endmodule

>>> rtl/motor_period_ramp_generator.sv
// motor period ramp generator, top level
// depends on mprg_pkg, mprg_if, mprg_apb, mprg_core, mprg_obuf
//
// req carries items: op (0 tick, 1 new target) and target_period. Every
// accepted item gives exactly one result on rsp: period, driver_enable and
// ramping. A command sets the goal, loads start_period if the driver is off,
// and restarts the dwell; a tick while ramping counts the dwell down and moves
// the period one count toward the goal when it runs out.
// Each result comes from the next state and is registered in the output or
// skid register as its item is accepted. Throughput is one item per cycle
// while req.ready is high, set by the single register stage on the state update.
// Results go to an output register backed by a skid register, so a new item
// is still taken while one result waits; req.ready drops only when both are
// full, and nothing is lost while rsp is stalled.
// The apb port holds six 8-bit registers at byte addresses 0 to 20; pready is
// always high and writes land at the access cycle. Configuration is to be
// written while the block is idle; the block itself does not enforce it.
// Reset clears period, goal, dwell, enable and ramping, empties the result
// buffer and loads the register defaults.
module motor_period_ramp_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	mprg_in_if.sink                            req,
	mprg_out_if.source                         rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mprg_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [mprg_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [mprg_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                               pready
);
	mprg_pkg::cfg_t cfg;
	mprg_pkg::res_t core_res, out_res;
	logic           can_push, accept;

	assign req.ready = can_push;
	assign accept = req.valid && can_push;

	mprg_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mprg_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.op            (req.op),
		.target_period (req.target_period),
		.cfg           (cfg),
		.res           (core_res)
	);

	mprg_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (core_res),
		.can_push  (can_push),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (out_res)
	);

	assign rsp.period = out_res.period;
	assign rsp.driver_enable = out_res.driver_enable;
	assign rsp.ramping = out_res.ramping;

endmodule

>>> dv/mprg_ramp_checker.sv
// period ramp checker: watches the item and result channels and the apb writes,
// predicts each result and compares it with what the block returns
// depends on mprg_pkg and mprg_if
module mprg_ramp_checker
	import mprg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	mprg_in_if                       req,
	mprg_out_if                      rsp,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output int unsigned              mismatches,
	output int unsigned              outstanding
);

	logic [CFG_BITS-1:0] start_period, high_thresh, low_thresh;
	logic [CFG_BITS-1:0] dwell_short, dwell_middle, dwell_long;

	logic [PERIOD_BITS-1:0] period_q;
	logic [PERIOD_BITS-1:0] goal_q;
	logic [DWELL_BITS-1:0]  dwell_q;
	logic                   enabled_q;
	logic                   moving_q;

	res_t        pending_results[$];
	int unsigned fail_cnt;

	function automatic logic [DWELL_BITS-1:0] dwell_for(input logic [PERIOD_BITS-1:0] p);
		if (p > high_thresh) begin
			return dwell_short;
		end else if (p > low_thresh) begin
			return dwell_middle;
		end
		return dwell_long;
	endfunction

	function automatic res_t advance_ramp(input op_t op, input logic [PERIOD_BITS-1:0] tgt);
		res_t r;
		if (op == OP_TARGET) begin
			goal_q = tgt;
			if (!enabled_q) begin
				period_q  = start_period;
				enabled_q = 1'b1;
			end
			moving_q = (period_q != goal_q);
			dwell_q  = dwell_for(period_q);
		end else if (moving_q) begin
			if (dwell_q > 1) begin
				dwell_q = dwell_q - 1'b1;
			end else begin
				if (period_q < goal_q) begin
					period_q = period_q + 1'b1;
				end else if (period_q > goal_q) begin
					period_q = period_q - 1'b1;
				end
				moving_q = (period_q != goal_q);
				dwell_q  = dwell_for(period_q);
			end
		end
		r.period        = period_q;
		r.driver_enable = enabled_q;
		r.ramping       = moving_q;
		return r;
	endfunction

	task automatic check_result();
		res_t want;
		if (pending_results.size() == 0) begin
			$display("%0t result with nothing pending: period %0d enable %0b ramping %0b",
				$time, rsp.period, rsp.driver_enable, rsp.ramping);
			fail_cnt++;
			return;
		end
		want = pending_results.pop_front();
		if (rsp.period !== want.period) begin
			$display("%0t period mismatch: expected %0d actual %0d",
				$time, want.period, rsp.period);
			fail_cnt++;
		end
		if (rsp.driver_enable !== want.driver_enable) begin
			$display("%0t driver_enable mismatch: expected %0b actual %0b",
				$time, want.driver_enable, rsp.driver_enable);
			fail_cnt++;
		end
		if (rsp.ramping !== want.ramping) begin
			$display("%0t ramping mismatch: expected %0b actual %0b",
				$time, want.ramping, rsp.ramping);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_period = START_PERIOD_RST;
			high_thresh  = HIGH_THRESH_RST;
			low_thresh   = LOW_THRESH_RST;
			dwell_short  = DWELL_SHORT_RST;
			dwell_middle = DWELL_MIDDLE_RST;
			dwell_long   = DWELL_LONG_RST;
			period_q     = '0;
			goal_q       = '0;
			dwell_q      = '0;
			enabled_q    = 1'b0;
			moving_q     = 1'b0;
			pending_results.delete();
			fail_cnt     = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				check_result();
			end
			if (req.valid && req.ready) begin
				pending_results.push_back(advance_ramp(op_t'(req.op), req.target_period));
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_ADDR_BITS-1:2]))
					REG_START_PERIOD: start_period = pwdata[CFG_BITS-1:0];
					REG_HIGH_THRESH:  high_thresh  = pwdata[CFG_BITS-1:0];
					REG_LOW_THRESH:   low_thresh   = pwdata[CFG_BITS-1:0];
					REG_DWELL_SHORT:  dwell_short  = pwdata[CFG_BITS-1:0];
					REG_DWELL_MIDDLE: dwell_middle = pwdata[CFG_BITS-1:0];
					REG_DWELL_LONG:   dwell_long   = pwdata[CFG_BITS-1:0];
					default: ;
				endcase
			end
			mismatches  <= fail_cnt;
			outstanding <= pending_results.size();
		end
	end

endmodule

>>> dv/tb_top.sv
// testbench top for the motor period ramp generator: clock, reset, apb
// configuration, item stimulus with idling phases, result back-pressure, verdict
// depends on mprg_pkg, mprg_if, mprg_ramp_checker and the block
module tb_top;
	import mprg_pkg::*;

	localparam int RAND_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 242;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned hold_reqs;
	int unsigned hold_seen;

	mprg_in_if  req_if();
	mprg_out_if rsp_if();

	motor_period_ramp_generator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mprg_ramp_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.rsp         (rsp_if),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5_000_000;
		$display("FAIL motor_period_ramp_generator");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		rsp_if.ready = 1'b0;
		hold_seen    = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_item(input op_t op, input logic [PERIOD_BITS-1:0] tgt);
		while ($urandom_range(99) < idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.op            <= op;
		req_if.target_period <= tgt;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input int idx, input logic [CFG_BITS-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_BITS'(idx * 4);
		pwdata  <= {(APB_DATA_BITS-CFG_BITS)'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_BITS-1:0] sp, input logic [CFG_BITS-1:0] hi,
		input logic [CFG_BITS-1:0] lo, input logic [CFG_BITS-1:0] ds,
		input logic [CFG_BITS-1:0] dm, input logic [CFG_BITS-1:0] dl);
		// unmapped slots past the last register must be ignored
		apb_write(int'(REG_DWELL_LONG) + 1, CFG_BITS'($urandom()));
		apb_write(int'(REG_DWELL_LONG) + 2, CFG_BITS'($urandom()));
		apb_write(int'(REG_START_PERIOD), sp);
		apb_write(int'(REG_HIGH_THRESH), hi);
		apb_write(int'(REG_LOW_THRESH), lo);
		apb_write(int'(REG_DWELL_SHORT), ds);
		apb_write(int'(REG_DWELL_MIDDLE), dm);
		apb_write(int'(REG_DWELL_LONG), dl);
	endtask

	function automatic logic [PERIOD_BITS-1:0] pick_target();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PERIOD_BITS'($urandom());
		endcase
	endfunction

	initial begin
		op_t op;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		req_if.valid         = 1'b0;
		req_if.op            = OP_TICK;
		req_if.target_period = '0;
		idle_pct             = 0;
		stall_pct            = 0;
		hold_reqs            = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: tick while disabled, enable, settle, retarget mid-ramp
		send_item(OP_TICK, '1);
		send_item(OP_TARGET, '0);
		repeat (5) send_item(OP_TICK, '0);
		send_item(OP_TARGET, PERIOD_BITS'(244));
		send_item(OP_TICK, '0);
		send_item(OP_TARGET, '1);
		repeat (6) send_item(OP_TICK, '1);
		send_item(OP_TARGET, '0);
		repeat (2) send_item(OP_TICK, '0);
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: configure(8'd245, 8'd150, 8'd50, 8'd1, 8'd2, 8'd3);
				1: configure('0, '0, '0, '0, '0, '0);
				2: configure('1, '1, '1, '1, '1, '1);
				3: configure(8'd128, 8'd10, 8'd200, 8'd2, 8'd3, 8'd4);
				6: configure(8'd77, 8'd200, 8'd100, 8'd1, 8'd4, 8'd2);
				default: configure(CFG_BITS'($urandom()), CFG_BITS'($urandom()),
					CFG_BITS'($urandom()), CFG_BITS'($urandom_range(6)),
					CFG_BITS'($urandom_range(6)), CFG_BITS'($urandom_range(6)));
			endcase
			case (ph % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 77;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 77;
				end
				default: begin
					idle_pct  = 37;
					stall_pct = 37;
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (ph == 0 && i == 50) begin
					hold_reqs++;
				end
				op = ($urandom_range(99) < 15) ? OP_TARGET : OP_TICK;
				send_item(op, pick_target());
			end
			drain();
		end

		idle_pct  = 0;
		stall_pct = 0;
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS motor_period_ramp_generator");
		end else begin
			$display("FAIL motor_period_ramp_generator");
		end
		$finish;
	end

endmodule
